### hw/rtl/assert_macros.svh
// Assertion helpers for the pump credit controller checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PCC_ASSERT_SAME(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error("pcc check failed");

// Antecedent implies consequent in the next cycle.
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error("pcc check failed");

`endif

### hw/rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

    localparam int CREDIT_W = 15;
    localparam int DAY_W    = 17;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 15'h7FFF;
    localparam logic [DAY_W-1:0]    DAY_SEC_MAX = 17'h1FFFF;
    localparam logic [7:0]          RUN_SEC_MAX = 8'hFF;

    localparam logic [2:0] REG_RUN_TIME    = 3'd0;
    localparam logic [2:0] REG_CREDIT_PRESS = 3'd1;
    localparam logic [2:0] REG_REFILL_CREDIT = 3'd2;
    localparam logic [2:0] REG_SEC_PER_DAY = 3'd3;
    localparam logic [2:0] REG_FRAME_GAP   = 3'd4;
    localparam logic [2:0] REG_FRAME_ON    = 3'd5;
    localparam logic [2:0] REG_SEQ_OFF     = 3'd6;
    localparam logic [2:0] REG_BLINK_SCALE = 3'd7;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_BROKEN = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_GAP       = 3'd0,
        PH_FRAME_ON  = 3'd1,
        PH_FAULT_OFF = 3'd2,
        PH_FAULT_ON  = 3'd3,
        PH_SEQ_OFF   = 3'd4,
        PH_SEQ_CALC  = 3'd5,
        PH_SEQ_ON    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BLINK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic action;
        logic tank_top_wet;
        logic tank_bottom_dry;
        logic button_down;
    } t_in_item;

    typedef struct packed {
        logic                pump_run;
        logic                led_lit;
        logic [CREDIT_W-1:0] credits_left;
        logic [1:0]          pump_mode;
        logic                limits_fault;
    } t_out_item;

    typedef struct packed {
        logic [7:0]          run_time_per_credit;
        logic [7:0]          credit_per_press;
        logic [CREDIT_W-1:0] refill_credit;
        logic [DAY_W-1:0]    seconds_per_day;
        logic [7:0]          frame_gap_ticks;
        logic [7:0]          frame_on_ticks;
        logic [7:0]          seq_off_ticks;
        logic [CREDIT_W-1:0] blink_scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
        logic div_start;
        logic blink;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_second;
        logic need_div;
        logic div_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/pcc_div.sv
`default_nettype none

module pcc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pcc_pkg::CREDIT_W-1:0] i_dividend,
    input  wire logic [pcc_pkg::CREDIT_W-1:0] i_divisor,
    output logic                              o_busy,
    output logic [pcc_pkg::CREDIT_W-1:0]      o_quotient
);
    import pcc_pkg::*;

    localparam int CNT_W = $clog2(CREDIT_W + 1);

    logic                r_busy, n_busy;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CREDIT_W-1:0] r_rem, n_rem;
    logic [CREDIT_W-1:0] r_quo, n_quo;
    logic [CREDIT_W-1:0] r_div, n_div;

    logic [CREDIT_W:0] shifted;
    logic [CREDIT_W:0] diff;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[CREDIT_W-1]};
        diff    = shifted - {1'b0, r_div};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(CREDIT_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_div}) begin
                n_rem = diff[CREDIT_W-1:0];
                n_quo = {r_quo[CREDIT_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[CREDIT_W-1:0];
                n_quo = {r_quo[CREDIT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### hw/rtl/pcc_datapath.sv
`default_nettype none

module pcc_datapath #(
    parameter int MAX_BLINK_RUN = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pcc_pkg::t_dp_cmd   i_cmd,
    output pcc_pkg::t_dp_stat       o_stat,
    input  wire pcc_pkg::t_cfg      i_cfg,
    input  wire pcc_pkg::t_in_item  i_in_data,
    output pcc_pkg::t_out_item      o_out_data
);
    import pcc_pkg::*;

    localparam logic [CREDIT_W-1:0] RUN_MAX  = CREDIT_W'(MAX_BLINK_RUN);
    localparam logic [7:0]          RUN_LEN  = 8'(MAX_BLINK_RUN);

    t_in_item            r_item;
    t_mode               r_mode, n_mode;
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic [7:0]          r_run_sec, n_run_sec;
    logic [DAY_W-1:0]    r_day_sec, n_day_sec;
    logic                r_fault, n_fault;
    logic                r_btn_prev, n_btn_prev;
    t_phase              r_phase, n_phase;
    logic [7:0]          r_ticks, n_ticks;
    logic [CREDIT_W-1:0] r_blinks, n_blinks;
    logic [7:0]          r_blink_len, n_blink_len;
    logic                r_led, n_led;
    t_out_item           r_out;

    logic                div_busy;
    logic [CREDIT_W-1:0] quotient;
    logic [CREDIT_W-1:0] scale;
    logic [7:0]          ticks_inc;

    assign scale     = (i_cfg.blink_scale == '0) ? CREDIT_W'(1) : i_cfg.blink_scale;
    assign ticks_inc = r_ticks + 8'd1;

    pcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_credit),
        .i_divisor  (scale),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_comb begin
        o_stat.is_second = r_item.action;
        o_stat.need_div  = !r_item.action
                           && ((r_phase == PH_FRAME_ON) || (r_phase == PH_FAULT_ON))
                           && (ticks_inc == i_cfg.frame_on_ticks);
        o_stat.div_busy  = div_busy;
    end

    always_comb begin
        logic [CREDIT_W:0]   sum;
        logic [CREDIT_W-1:0] blinks_tmp;
        logic [7:0]          len_tmp;

        n_mode      = r_mode;
        n_credit    = r_credit;
        n_run_sec   = r_run_sec;
        n_day_sec   = r_day_sec;
        n_fault     = r_fault;
        n_btn_prev  = r_btn_prev;
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_blinks    = r_blinks;
        n_blink_len = r_blink_len;
        n_led       = r_led;
        sum         = '0;
        blinks_tmp  = r_blinks;
        len_tmp     = r_blink_len;

        if (i_cmd.step) begin
            if (r_item.action) begin
                if (r_day_sec != DAY_SEC_MAX) begin
                    n_day_sec = r_day_sec + DAY_W'(1);
                end
                if ((r_mode == MODE_ON) && (r_run_sec != RUN_SEC_MAX)) begin
                    n_run_sec = r_run_sec + 8'd1;
                end
            end else begin
                case (r_mode)
                    MODE_BROKEN: begin
                        if (!(r_item.tank_top_wet && r_item.tank_bottom_dry)) begin
                            n_mode = MODE_OFF;
                        end
                    end
                    MODE_ON: begin
                        if (r_item.tank_top_wet && r_item.tank_bottom_dry) begin
                            n_mode   = MODE_BROKEN;
                            n_fault  = 1'b1;
                            n_credit = '0;
                        end else begin
                            if (r_item.tank_top_wet) begin
                                n_mode = MODE_OFF;
                            end
                            if (r_run_sec >= i_cfg.run_time_per_credit) begin
                                if (r_credit != '0) begin
                                    n_credit  = r_credit - CREDIT_W'(1);
                                    n_run_sec = '0;
                                end else begin
                                    n_mode = MODE_OFF;
                                end
                            end
                        end
                    end
                    MODE_OFF: begin
                        if (r_item.tank_bottom_dry && (r_credit != '0)) begin
                            n_mode    = MODE_ON;
                            n_run_sec = '0;
                        end
                    end
                    default: begin
                        n_mode = MODE_OFF;
                    end
                endcase

                if (r_item.button_down && !r_btn_prev) begin
                    sum = {1'b0, n_credit} + (CREDIT_W + 1)'(i_cfg.credit_per_press);
                    if (sum > {1'b0, CREDIT_MAX}) begin
                        n_credit = CREDIT_MAX;
                    end else begin
                        n_credit = sum[CREDIT_W-1:0];
                    end
                end
                n_btn_prev = r_item.button_down;
            end
        end

        if (i_cmd.blink) begin
            n_ticks = ticks_inc;
            case (r_phase)
                PH_GAP: begin
                    if (ticks_inc == i_cfg.frame_gap_ticks) begin
                        n_phase = PH_FRAME_ON;
                        n_ticks = '0;
                        n_led   = 1'b1;
                    end
                end
                PH_FRAME_ON: begin
                    if (ticks_inc == i_cfg.frame_on_ticks) begin
                        n_phase  = r_fault ? PH_FAULT_OFF : PH_SEQ_OFF;
                        n_ticks  = '0;
                        n_led    = 1'b0;
                        n_blinks = quotient;
                    end
                end
                PH_FAULT_OFF: begin
                    if (ticks_inc == i_cfg.frame_gap_ticks) begin
                        n_phase = PH_FAULT_ON;
                        n_ticks = '0;
                        n_led   = 1'b1;
                    end
                end
                PH_FAULT_ON: begin
                    if (ticks_inc == i_cfg.frame_on_ticks) begin
                        n_phase  = PH_SEQ_OFF;
                        n_ticks  = '0;
                        n_led    = 1'b0;
                        n_blinks = quotient;
                    end
                end
                PH_SEQ_OFF: begin
                    if (r_blinks != '0) begin
                        if (ticks_inc == i_cfg.seq_off_ticks) begin
                            n_phase = PH_SEQ_CALC;
                            n_ticks = '0;
                            n_led   = 1'b1;
                        end
                    end else begin
                        n_phase = PH_GAP;
                        n_led   = 1'b0;
                    end
                end
                PH_SEQ_CALC, PH_SEQ_ON: begin
                    if (r_phase == PH_SEQ_CALC) begin
                        if (r_blinks >= RUN_MAX) begin
                            len_tmp    = RUN_LEN;
                            blinks_tmp = r_blinks - RUN_MAX;
                        end else begin
                            len_tmp    = r_blinks[7:0];
                            blinks_tmp = '0;
                        end
                        n_phase = PH_SEQ_ON;
                    end
                    n_blink_len = len_tmp;
                    n_blinks    = blinks_tmp;
                    if (ticks_inc >= len_tmp) begin
                        n_phase = PH_SEQ_OFF;
                        n_ticks = '0;
                        n_led   = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_GAP;
                end
            endcase

            if (r_day_sec >= i_cfg.seconds_per_day) begin
                n_day_sec = '0;
                if (r_credit <= i_cfg.refill_credit) begin
                    n_credit = i_cfg.refill_credit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_credit    <= '0;
            r_run_sec   <= '0;
            r_day_sec   <= '0;
            r_fault     <= 1'b0;
            r_btn_prev  <= 1'b0;
            r_phase     <= PH_GAP;
            r_ticks     <= '0;
            r_blinks    <= '0;
            r_blink_len <= '0;
            r_led       <= 1'b1;
        end else begin
            r_mode      <= n_mode;
            r_credit    <= n_credit;
            r_run_sec   <= n_run_sec;
            r_day_sec   <= n_day_sec;
            r_fault     <= n_fault;
            r_btn_prev  <= n_btn_prev;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_blinks    <= n_blinks;
            r_blink_len <= n_blink_len;
            r_led       <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.out_load) begin
            r_out.pump_run     <= (r_mode == MODE_ON);
            r_out.led_lit      <= r_led;
            r_out.credits_left <= r_credit;
            r_out.pump_mode    <= r_mode;
            r_out.limits_fault <= r_fault;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

### hw/rtl/pcc_ctrl.sv
`default_nettype none

module pcc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pcc_pkg::t_dp_cmd        o_cmd,
    input  wire pcc_pkg::t_dp_stat  i_stat
);
    import pcc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (i_stat.is_second) begin
                    n_state = ST_OUT;
                end else if (i_stat.need_div) begin
                    n_state = ST_DIV_GO;
                end else begin
                    n_state = ST_BLINK;
                end
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_BLINK;
                end
            end
            ST_BLINK: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                o_cmd = '0;
            end
            ST_BLINK: begin
                o_cmd.blink = 1'b1;
            end
            ST_OUT: begin
                o_cmd.out_load = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hw/rtl/pump_credit_controller.sv
// Pump controller with a credit budget. Each input beat is a main-loop tick
// (action 0) or a one-second tick (action 1) and gives exactly one result beat
// with pump drive, LED, credit balance, pump mode and the sticky limits fault.
// One item is worked at a time: a second tick passes from accept through the
// step and output states, a main tick also through the blink state, and one
// that ends a frame-on or fault-on phase also waits on the 15-step restoring
// divider that forms credits / blink_scale. A finished result waits in an
// output register while the next beat is accepted. Registers sit on the APB
// port at byte address 4*index; write them only while the block is idle.
`default_nettype none

module pump_credit_controller #(
    parameter int MAX_BLINK_RUN = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pcc_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pcc_pkg::t_out_item      o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import pcc_pkg::*;

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_time_per_credit <= 8'd60;
            r_cfg.credit_per_press    <= 8'd10;
            r_cfg.refill_credit       <= 15'd10;
            r_cfg.seconds_per_day     <= 17'd86400;
            r_cfg.frame_gap_ticks     <= 8'd10;
            r_cfg.frame_on_ticks      <= 8'd2;
            r_cfg.seq_off_ticks       <= 8'd3;
            r_cfg.blink_scale         <= 15'd1;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RUN_TIME:      r_cfg.run_time_per_credit <= pwdata[7:0];
                REG_CREDIT_PRESS:  r_cfg.credit_per_press    <= pwdata[7:0];
                REG_REFILL_CREDIT: r_cfg.refill_credit       <= pwdata[CREDIT_W-1:0];
                REG_SEC_PER_DAY:   r_cfg.seconds_per_day     <= pwdata[DAY_W-1:0];
                REG_FRAME_GAP:     r_cfg.frame_gap_ticks     <= pwdata[7:0];
                REG_FRAME_ON:      r_cfg.frame_on_ticks      <= pwdata[7:0];
                REG_SEQ_OFF:       r_cfg.seq_off_ticks       <= pwdata[7:0];
                REG_BLINK_SCALE:   r_cfg.blink_scale         <= pwdata[CREDIT_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RUN_TIME:      prdata = 32'(r_cfg.run_time_per_credit);
            REG_CREDIT_PRESS:  prdata = 32'(r_cfg.credit_per_press);
            REG_REFILL_CREDIT: prdata = 32'(r_cfg.refill_credit);
            REG_SEC_PER_DAY:   prdata = 32'(r_cfg.seconds_per_day);
            REG_FRAME_GAP:     prdata = 32'(r_cfg.frame_gap_ticks);
            REG_FRAME_ON:      prdata = 32'(r_cfg.frame_on_ticks);
            REG_SEQ_OFF:       prdata = 32'(r_cfg.seq_off_ticks);
            REG_BLINK_SCALE:   prdata = 32'(r_cfg.blink_scale);
            default:           prdata = '0;
        endcase
    end

    pcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    pcc_datapath #(
        .MAX_BLINK_RUN (MAX_BLINK_RUN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

### hw/rtl/pcc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pcc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire pcc_pkg::t_out_item o_out_data
);
    import pcc_pkg::*;

    logic in_beat;
    logic out_held;
    logic run_ok;
    logic shows_broken;
    logic shows_fault;

    assign in_beat      = i_in_valid && !o_in_stall;
    assign out_held     = o_out_valid && i_out_stall;
    assign run_ok       = o_out_data.pump_run == (o_out_data.pump_mode == MODE_ON);
    assign shows_broken = o_out_valid && (o_out_data.pump_mode == MODE_BROKEN);
    assign shows_fault  = o_out_valid && o_out_data.limits_fault;

    // one item at a time: an accepted beat closes the input side
    `PCC_ASSERT_NEXT(a_stall_after_accept, i_clk, i_rst_n, in_beat, o_in_stall)

    // held result stays put while stalled
    `PCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))

    `PCC_ASSERT_SAME(a_run_matches_mode, i_clk, i_rst_n, o_out_valid, run_ok)

    `PCC_ASSERT_SAME(a_broken_has_fault, i_clk, i_rst_n, shows_broken, o_out_data.limits_fault)

    // fault is sticky in the result register
    `PCC_ASSERT_NEXT(a_fault_sticky, i_clk, i_rst_n, shows_fault, o_out_data.limits_fault)

endmodule

bind pump_credit_controller pcc_checker u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
